// ===== sv/nalsplit_pkg.sv =====
// Shared types and constants for the Annex B start code splitter.
// No dependencies; every other file refers to this package by scoped names.
package nalsplit_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1048576;

  localparam int POS_W   = 21;
  localparam int TOTAL_W = 22;
  localparam int INDEX_W = 20;
  localparam int BYTE_W  = 8;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES);

  localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;
  localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [2:0]        SC_LONG_LEN  = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one closed unit as found by the scanner
  typedef struct packed {
    logic [POS_W-1:0] in_offset;
    logic [POS_W-1:0] length;
    logic             final_unit;
  } unit_evt_t;

  // scanner -> queue write group; cnt is 0, 1 or 2, entries packed from e0
  typedef struct packed {
    logic [1:0] cnt;
    unit_evt_t  e0;
    unit_evt_t  e1;
  } queue_wr_t;

  // queue -> back end read group
  typedef struct packed {
    logic      not_empty;
    unit_evt_t head;
  } queue_rd_t;

endpackage

// ===== sv/nalsplit_if.sv =====
// Valid/ready channel interfaces for the splitter's byte input and unit output.
// Depends on nalsplit_pkg for field widths.
interface nalsplit_in_if;
  logic                            valid;
  logic                            ready;
  logic [nalsplit_pkg::BYTE_W-1:0] data_byte;
  logic                            packet_end;

  modport source (output valid, data_byte, packet_end, input ready);
  modport sink   (input valid, data_byte, packet_end, output ready);
endinterface

interface nalsplit_out_if;
  logic                             valid;
  logic                             ready;
  logic [nalsplit_pkg::POS_W-1:0]   unit_in_offset;
  logic [nalsplit_pkg::TOTAL_W-1:0] unit_out_offset;
  logic [nalsplit_pkg::POS_W-1:0]   unit_length;
  logic [nalsplit_pkg::INDEX_W-1:0] unit_index;
  logic                             final_unit;

  modport source (output valid, unit_in_offset, unit_out_offset, unit_length, unit_index,
                  final_unit, input ready);
  modport sink   (input valid, unit_in_offset, unit_out_offset, unit_length, unit_index,
                  final_unit, output ready);
endinterface

// ===== sv/annexb_nal_start_code_splitter_unit.sv =====
// Annex B NAL unit splitter, top level: scanner, unit queue and emit stage.
// Depends on nalsplit_pkg, nalsplit_if, nalsplit_scan, nalsplit_queue, nalsplit_emit.
//
// Takes one packet byte per cycle and reports one transaction per NAL unit it
// closes: input payload offset, payload length, offset in a stream where every
// start code is four bytes, and unit index. A byte is taken every cycle as long
// as the four-entry unit queue has two free slots (a byte can close two units
// when a start code ends the packet); the emit stage drains one unit per cycle,
// so a stall on the output only backs up into the input once the queue fills.
// out_valid for a unit rises once the emit stage pops it from the queue into its
// result register; when one byte closes two units, the second is popped after the first.
module annexb_nal_start_code_splitter_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  nalsplit_in_if.sink           in_ch,
  nalsplit_out_if.source        out_ch
);

  nalsplit_pkg::queue_wr_t wr;
  nalsplit_pkg::queue_rd_t rd;
  logic                    space_ok;
  logic                    pop;

  nalsplit_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .data_byte  (in_ch.data_byte),
    .packet_end (in_ch.packet_end),
    .space_ok   (space_ok),
    .wr         (wr)
  );

  nalsplit_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .space_ok (space_ok),
    .pop      (pop),
    .rd       (rd)
  );

  nalsplit_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .rd              (rd),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .unit_in_offset  (out_ch.unit_in_offset),
    .unit_out_offset (out_ch.unit_out_offset),
    .unit_length     (out_ch.unit_length),
    .unit_index      (out_ch.unit_index),
    .final_unit      (out_ch.final_unit)
  );

endmodule

// ===== sv/nalsplit_scan.sv =====
// Front end: byte history, start code detection and unit boundary tracking.
// Depends on nalsplit_pkg; writes closed units into nalsplit_queue.
module nalsplit_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nalsplit_pkg::BYTE_W-1:0]  data_byte,
  input  logic                             packet_end,
  input  logic                             space_ok,
  output nalsplit_pkg::queue_wr_t          wr
);

  logic [3*nalsplit_pkg::BYTE_W-1:0] recent_r;
  logic [nalsplit_pkg::POS_W-1:0]    pos_r;
  logic [nalsplit_pkg::POS_W-1:0]    ous_r;
  logic                              open_r;

  logic                              acc;
  logic                              in_range;
  logic                              sc_hit;
  logic                              sc_long;
  logic [nalsplit_pkg::POS_W-1:0]    code_start;
  logic [nalsplit_pkg::POS_W-1:0]    len_a;
  logic [nalsplit_pkg::POS_W-1:0]    len_f;
  logic [nalsplit_pkg::POS_W-1:0]    ous_nxt;
  logic [nalsplit_pkg::POS_W-1:0]    pos_nxt;
  logic                              open_nxt;
  logic                              ev_a;
  logic                              ev_f;

  assign in_ready = space_ok;
  assign acc      = in_valid && space_ok;

  always_comb begin
    in_range = pos_r < nalsplit_pkg::POS_LIMIT;
    sc_hit   = in_range && (data_byte == nalsplit_pkg::SC_LAST_BYTE) &&
               (pos_r >= nalsplit_pkg::POS_W'(2)) &&
               (recent_r[2*nalsplit_pkg::BYTE_W-1:0] == '0);
    sc_long  = (pos_r >= nalsplit_pkg::POS_W'(3)) &&
               (recent_r[3*nalsplit_pkg::BYTE_W-1:2*nalsplit_pkg::BYTE_W] ==
                nalsplit_pkg::SC_ZERO_BYTE);
    // first byte of the start code: position + 1 - code length
    code_start = sc_long ? pos_r - nalsplit_pkg::POS_W'(3) : pos_r - nalsplit_pkg::POS_W'(2);
    len_a      = (code_start >= ous_r) ? code_start - ous_r : '0;

    ous_nxt  = sc_hit ? pos_r + nalsplit_pkg::POS_W'(1) : ous_r;
    open_nxt = open_r || sc_hit;
    pos_nxt  = in_range ? pos_r + nalsplit_pkg::POS_W'(1) : pos_r;
    len_f    = (pos_nxt >= ous_nxt) ? pos_nxt - ous_nxt : '0;

    ev_a = sc_hit && open_r;
    ev_f = packet_end && open_nxt;

    wr.cnt = acc ? ({1'b0, ev_a} + {1'b0, ev_f}) : 2'd0;
    wr.e1  = '{in_offset: ous_nxt, length: len_f, final_unit: 1'b1};
    if (ev_a) begin
      wr.e0 = '{in_offset: ous_r, length: len_a, final_unit: 1'b0};
    end else begin
      wr.e0 = wr.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      pos_r    <= '0;
      ous_r    <= '0;
      open_r   <= 1'b0;
    end else if (acc) begin
      if (packet_end) begin
        recent_r <= '0;
        pos_r    <= '0;
        ous_r    <= '0;
        open_r   <= 1'b0;
      end else begin
        if (in_range) begin
          recent_r <= {recent_r[2*nalsplit_pkg::BYTE_W-1:0], data_byte};
        end
        pos_r  <= pos_nxt;
        ous_r  <= ous_nxt;
        open_r <= open_nxt;
      end
    end
  end

endmodule

// ===== sv/nalsplit_queue.sv =====
// Four-entry queue between scanner and back end; takes up to two units a cycle.
// Depends on nalsplit_pkg.
module nalsplit_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nalsplit_pkg::queue_wr_t wr,
  output logic                    space_ok,
  input  logic                    pop,
  output nalsplit_pkg::queue_rd_t rd
);

  nalsplit_pkg::unit_evt_t              mem [nalsplit_pkg::QUEUE_DEPTH];
  logic [nalsplit_pkg::QPTR_W-1:0]      wptr_r;
  logic [nalsplit_pkg::QPTR_W-1:0]      rptr_r;
  logic [nalsplit_pkg::QCNT_W-1:0]      count_r;
  logic [nalsplit_pkg::QPTR_W-1:0]      wptr_inc;

  assign space_ok     = count_r <= nalsplit_pkg::QCNT_W'(nalsplit_pkg::QUEUE_DEPTH - 2);
  assign rd.not_empty = count_r != '0;
  assign rd.head      = mem[rptr_r];
  assign wptr_inc     = wptr_r + nalsplit_pkg::QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wptr_r] <= wr.e0;
    end
    if (wr.cnt == 2'd2) begin
      mem[wptr_inc] <= wr.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + nalsplit_pkg::QPTR_W'(wr.cnt);
      rptr_r  <= rptr_r + nalsplit_pkg::QPTR_W'(pop);
      count_r <= count_r + nalsplit_pkg::QCNT_W'(wr.cnt) - nalsplit_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== sv/nalsplit_emit.sv =====
// Back end: assigns output offset and index to each unit, holds the result register.
// Depends on nalsplit_pkg; reads from nalsplit_queue.
module nalsplit_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nalsplit_pkg::queue_rd_t          rd,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nalsplit_pkg::POS_W-1:0]   unit_in_offset,
  output logic [nalsplit_pkg::TOTAL_W-1:0] unit_out_offset,
  output logic [nalsplit_pkg::POS_W-1:0]   unit_length,
  output logic [nalsplit_pkg::INDEX_W-1:0] unit_index,
  output logic                             final_unit
);

  logic [nalsplit_pkg::TOTAL_W-1:0] total_r;
  logic [nalsplit_pkg::INDEX_W-1:0] count_r;
  logic                             valid_r;
  logic [nalsplit_pkg::POS_W-1:0]   in_off_r;
  logic [nalsplit_pkg::TOTAL_W-1:0] out_off_r;
  logic [nalsplit_pkg::POS_W-1:0]   len_r;
  logic [nalsplit_pkg::INDEX_W-1:0] idx_r;
  logic                             fin_r;
  logic [nalsplit_pkg::TOTAL_W-1:0] out_off_nxt;
  logic [nalsplit_pkg::TOTAL_W-1:0] total_nxt;

  assign pop             = rd.not_empty && (!valid_r || out_ready);
  assign out_valid       = valid_r;
  assign unit_in_offset  = in_off_r;
  assign unit_out_offset = out_off_r;
  assign unit_length     = len_r;
  assign unit_index      = idx_r;
  assign final_unit      = fin_r;

  always_comb begin
    out_off_nxt = total_r + nalsplit_pkg::TOTAL_W'(nalsplit_pkg::SC_LONG_LEN);
    total_nxt   = out_off_nxt + nalsplit_pkg::TOTAL_W'(rd.head.length);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= '0;
      count_r <= '0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        if (rd.head.final_unit) begin
          total_r <= '0;
          count_r <= '0;
        end else begin
          total_r <= total_nxt;
          count_r <= count_r + nalsplit_pkg::INDEX_W'(1);
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      in_off_r  <= rd.head.in_offset;
      out_off_r <= out_off_nxt;
      len_r     <= rd.head.length;
      idx_r     <= count_r;
      fin_r     <= rd.head.final_unit;
    end
  end

endmodule

// ===== sv/nalsplit_chk.sv =====
// Port-level checker for the splitter top level, attached by bind below.
// Depends on nalsplit_pkg and the top level's interface ports.
module nalsplit_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [nalsplit_pkg::POS_W-1:0]   unit_in_offset,
  input logic [nalsplit_pkg::TOTAL_W-1:0] unit_out_offset,
  input logic [nalsplit_pkg::POS_W-1:0]   unit_length,
  input logic [nalsplit_pkg::INDEX_W-1:0] unit_index,
  input logic                             final_unit
);

  logic                             prev_fin_r;
  logic [nalsplit_pkg::INDEX_W-1:0] prev_idx_r;
  logic [nalsplit_pkg::TOTAL_W-1:0] prev_end_r;
  logic                             out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_fin_r <= 1'b1;
      prev_idx_r <= '0;
      prev_end_r <= '0;
    end else if (out_acc) begin
      prev_fin_r <= final_unit;
      prev_idx_r <= unit_index;
      prev_end_r <= unit_out_offset + nalsplit_pkg::TOTAL_W'(unit_length);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(unit_index) && $stable(unit_length))
    else $error("stalled transaction changed");

  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (prev_fin_r ? unit_index == '0
                            : unit_index == prev_idx_r + nalsplit_pkg::INDEX_W'(1)))
    else $error("unit index out of sequence");

  a_out_offset_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> unit_out_offset == (prev_fin_r ? nalsplit_pkg::TOTAL_W'(4)
                                               : prev_end_r + nalsplit_pkg::TOTAL_W'(4)))
    else $error("output offset does not follow previous unit");

  a_in_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> unit_in_offset >= nalsplit_pkg::POS_W'(3))
    else $error("unit payload starts before any start code could end");

endmodule

bind annexb_nal_start_code_splitter_unit nalsplit_chk u_nalsplit_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .unit_in_offset  (out_ch.unit_in_offset),
  .unit_out_offset (out_ch.unit_out_offset),
  .unit_length     (out_ch.unit_length),
  .unit_index      (out_ch.unit_index),
  .final_unit      (out_ch.final_unit)
);
